// File: hdl/tksel_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score selector package
// Shared widths, defaults and the configuration reset value.
// ----------------------------------------------------------------------------
package tksel_pkg;

   localparam int K_MAX_DEFAULT     = 8;
   localparam int VOCAB_MAX_DEFAULT = 262144;

   localparam int SCORE_W    = 16;
   localparam int OUT_IDX_W  = 18;
   localparam int RANK_W     = 3;
   localparam int KEEP_W     = 4;

   // Input tdata: score, padded to whole bytes.
   localparam int REQ_DATA_W = ((SCORE_W + 7) / 8) * 8;
   // Result tdata: element_index, selected_score, rank, padded to whole bytes.
   localparam int RSP_FIELDS_W = OUT_IDX_W + SCORE_W + RANK_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd5;

endpackage

// File: hdl/tksel_insert.sv
// ----------------------------------------------------------------------------
// Top-k insertion stage
// Input register, sorted list of the best scores, position counter, and the
// snapshot of the list handed to the result buffer at the end of a vector.
// ----------------------------------------------------------------------------
module tksel_insert #(
   parameter int K_MAX     = tksel_pkg::K_MAX_DEFAULT,
   parameter int VOCAB_MAX = tksel_pkg::VOCAB_MAX_DEFAULT,
   parameter int IDX_W     = $clog2(VOCAB_MAX),
   parameter int CNT_W     = $clog2(K_MAX + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [tksel_pkg::SCORE_W-1:0] in_score,
   input  logic                                in_last,
   input  logic [tksel_pkg::KEEP_W-1:0]         keep_count,
   output logic                                snap_valid,
   input  logic                                snap_ready,
   output logic [CNT_W-1:0]                    snap_count,
   output logic signed [tksel_pkg::SCORE_W-1:0] snap_score [K_MAX],
   output logic [IDX_W-1:0]                    snap_index [K_MAX]
);
   import tksel_pkg::*;

   localparam logic [IDX_W-1:0] POS_MAX = IDX_W'(VOCAB_MAX - 1);
   localparam logic [CNT_W-1:0] K_CNT   = CNT_W'(K_MAX);

   logic                      item_valid_ff;
   logic signed [SCORE_W-1:0] item_score_ff;
   logic                      item_last_ff;
   logic                      advance;
   logic                      update;

   logic signed [SCORE_W-1:0] best_score_ff [K_MAX];
   logic [IDX_W-1:0]          best_index_ff [K_MAX];
   logic [CNT_W-1:0]          filled_ff;
   logic [CNT_W-1:0]          filled_in;
   logic [IDX_W-1:0]          position_ff;
   logic [IDX_W-1:0]          position_in;

   logic [K_MAX:1]            ge_ext;
   logic signed [SCORE_W-1:0] next_score [K_MAX];
   logic [IDX_W-1:0]          next_index [K_MAX];
   logic [CNT_W-1:0]          keep_eff;

   // The item in the register moves on unless it closes a vector while the
   // result buffer is still busy with the previous one.
   assign advance  = !item_valid_ff || !item_last_ff || snap_ready;
   assign in_ready = advance;
   assign update   = item_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (advance) begin
         item_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_score_ff <= in_score;
         item_last_ff  <= in_last;
      end
   end

   // An entry stays in place when it is held and at least as large as the new
   // score; equal scores keep the earlier index ahead.
   for (genvar i = 0; i < K_MAX; i++) begin : g_cmp
      assign ge_ext[i+1] = (CNT_W'(i) < filled_ff) && (best_score_ff[i] >= item_score_ff);
   end

   for (genvar i = 0; i < K_MAX; i++) begin : g_next
      if (i == 0) begin : g_head
         always_comb begin
            if (ge_ext[1]) begin
               next_score[i] = best_score_ff[i];
               next_index[i] = best_index_ff[i];
            end else begin
               next_score[i] = item_score_ff;
               next_index[i] = position_ff;
            end
         end
      end else begin : g_body
         always_comb begin
            if (ge_ext[i+1]) begin
               next_score[i] = best_score_ff[i];
               next_index[i] = best_index_ff[i];
            end else if (ge_ext[i]) begin
               next_score[i] = item_score_ff;
               next_index[i] = position_ff;
            end else begin
               next_score[i] = best_score_ff[i-1];
               next_index[i] = best_index_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      if (filled_ff < K_CNT) begin
         filled_in = filled_ff + 1'b1;
      end else begin
         filled_in = filled_ff;
      end
      if (position_ff < POS_MAX) begin
         position_in = position_ff + 1'b1;
      end else begin
         position_in = position_ff;
      end
   end

   // Reported count: keep_count clamped to the range 1 to K_MAX, then limited
   // to the entries actually held.
   always_comb begin
      if (keep_count == '0) begin
         keep_eff = CNT_W'(1);
      end else if (32'(keep_count) > K_MAX) begin
         keep_eff = K_CNT;
      end else begin
         keep_eff = CNT_W'(keep_count);
      end
      if (filled_in < keep_eff) begin
         snap_count = filled_in;
      end else begin
         snap_count = keep_eff;
      end
   end

   assign snap_valid = item_valid_ff && item_last_ff;
   assign snap_score = next_score;
   assign snap_index = next_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff   <= '0;
         position_ff <= '0;
      end else if (update) begin
         if (item_last_ff) begin
            filled_ff   <= '0;
            position_ff <= '0;
         end else begin
            filled_ff   <= filled_in;
            position_ff <= position_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         best_score_ff <= next_score;
         best_index_ff <= next_index;
      end
   end

endmodule

// File: hdl/tksel_drain.sv
// ----------------------------------------------------------------------------
// Top-k result buffer
// Holds the snapshot of one finished vector and shifts it out one result per
// transaction, numbering ranks and marking the final result.
// ----------------------------------------------------------------------------
module tksel_drain #(
   parameter int K_MAX     = tksel_pkg::K_MAX_DEFAULT,
   parameter int VOCAB_MAX = tksel_pkg::VOCAB_MAX_DEFAULT,
   parameter int IDX_W     = $clog2(VOCAB_MAX),
   parameter int CNT_W     = $clog2(K_MAX + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 snap_valid,
   output logic                                 snap_ready,
   input  logic [CNT_W-1:0]                     snap_count,
   input  logic signed [tksel_pkg::SCORE_W-1:0] snap_score [K_MAX],
   input  logic [IDX_W-1:0]                     snap_index [K_MAX],
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [tksel_pkg::RSP_DATA_W-1:0]     out_data,
   output logic                                 out_last
);
   import tksel_pkg::*;

   logic signed [SCORE_W-1:0] score_ff [K_MAX];
   logic [IDX_W-1:0]          index_ff [K_MAX];
   logic [CNT_W-1:0]          left_ff;
   logic [RANK_W-1:0]         rank_ff;
   logic                      take;
   logic                      load;
   logic [IDX_W+OUT_IDX_W-1:0] index_ext;

   assign out_valid  = (left_ff != '0);
   assign out_last   = (left_ff == CNT_W'(1));
   assign take       = out_valid && out_ready;
   assign snap_ready = !out_valid || (out_last && out_ready);
   assign load       = snap_valid && snap_ready;

   // Element index is carried at the counter width and cut or padded to the
   // field width.
   assign index_ext = {{OUT_IDX_W{1'b0}}, index_ff[0]};
   assign out_data  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rank_ff, score_ff[0],
                       index_ext[OUT_IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rank_ff <= '0;
      end else if (load) begin
         left_ff <= snap_count;
         rank_ff <= '0;
      end else if (take) begin
         left_ff <= left_ff - 1'b1;
         rank_ff <= rank_ff + 1'b1;
      end
   end

   for (genvar i = 0; i < K_MAX; i++) begin : g_buf
      always_ff @(posedge clock) begin
         if (load) begin
            score_ff[i] <= snap_score[i];
            index_ff[i] <= snap_index[i];
         end else if (take) begin
            if (i < K_MAX - 1) begin
               score_ff[i] <= score_ff[(i + 1) % K_MAX];
               index_ff[i] <= index_ff[(i + 1) % K_MAX];
            end
         end
      end
   end

endmodule

// File: hdl/top_k_score_selector.sv
// ----------------------------------------------------------------------------
// Top-k score selector
// Keeps the best scores of a stream with their positions and reports them in
// descending order at the end of each vector.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req_    | in        | tdata: score[15:0]; tlast: last_element
//  rsp_    | out       | tdata: element_index, selected_score, rank; tlast: last_result
//  csr_    | in        | data: keep_count[3:0]
//
// One score is accepted per cycle when req_tready is high; insertion compares all kept
// entries at once. Results are valid once a vector's last score passed the input
// register into the result buffer: max(1, min(keep_count, entries held)) of them,
// one per cycle when rsp_tready is high. That last score waits in the input register
// while the result buffer holds results of the previous vector, unless its final one is
// taken in that cycle. Reset clears the counters and sets keep_count to 5.
// ----------------------------------------------------------------------------
module top_k_score_selector #(
   parameter int K_MAX     = tksel_pkg::K_MAX_DEFAULT,
   parameter int VOCAB_MAX = tksel_pkg::VOCAB_MAX_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tksel_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] score
   input  logic                                req_tlast,  // last_element
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [17:0] element_index, [33:18] selected_score, [36:34] rank
   output logic [tksel_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,  // last_result
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tksel_pkg::KEEP_W-1:0]        csr_data
);
   import tksel_pkg::*;

   localparam int IDX_W = $clog2(VOCAB_MAX);
   localparam int CNT_W = $clog2(K_MAX + 1);

   logic [KEEP_W-1:0]         keep_ff;
   logic                      snap_valid;
   logic                      snap_ready;
   logic [CNT_W-1:0]          snap_count;
   logic signed [SCORE_W-1:0] snap_score [K_MAX];
   logic [IDX_W-1:0]          snap_index [K_MAX];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_ff <= csr_data;
      end
   end

   tksel_insert #(
      .K_MAX     (K_MAX),
      .VOCAB_MAX (VOCAB_MAX),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_insert (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_score   (req_tdata[SCORE_W-1:0]),
      .in_last    (req_tlast),
      .keep_count (keep_ff),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_count (snap_count),
      .snap_score (snap_score),
      .snap_index (snap_index)
   );

   tksel_drain #(
      .K_MAX     (K_MAX),
      .VOCAB_MAX (VOCAB_MAX),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_count (snap_count),
      .snap_score (snap_score),
      .snap_index (snap_index),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
